>>> hdl/mbps_pkg.sv
// ----------------------------------------------------------------------------
// mbps_pkg
// shared types, constants and register codes of the masked byte pattern scanner
// ----------------------------------------------------------------------------
package mbps_pkg;

	// parameter defaults
	localparam int PATTERN_BYTES_DEF = 16;
	localparam int ADDRESS_BITS_DEF  = 48;
	localparam int QUEUE_DEPTH_DEF   = 4;

	// fixed field widths
	localparam int REG_BYTES     = 16;   // pattern bytes backed by a register
	localparam int LEN_BITS      = 5;
	localparam int HIT_BITS      = 16;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 64;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_LOW    = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_HIGH   = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_COMPARE_MASK   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_LENGTH = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_HITS       = 3'd4;

	typedef struct packed {
		logic [8*REG_BYTES-1:0] pattern;        // byte i at bits 8i+7..8i
		logic [REG_BYTES-1:0]   compare_mask;
		logic [LEN_BITS-1:0]    pattern_length;
		logic [HIT_BITS-1:0]    max_hits;
	} cfg_regs_t;

endpackage

>>> hdl/mbps_if.sv
// ----------------------------------------------------------------------------
// mbps channel interfaces
// byte stream, result and configuration write channels with valid/ready
// ----------------------------------------------------------------------------
interface mbps_stream_if import mbps_pkg::*; #(
	parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
);
	logic                    valid;
	logic                    ready;
	logic [7:0]              data_byte;
	logic [ADDRESS_BITS-1:0] byte_address;
	logic                    span_start;
	logic                    end_of_scan;

	modport source (output valid, data_byte, byte_address, span_start, end_of_scan,
		input ready);
	modport sink (input valid, data_byte, byte_address, span_start, end_of_scan,
		output ready);
endinterface

interface mbps_result_if import mbps_pkg::*; #(
	parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
);
	logic                    valid;
	logic                    ready;
	logic                    is_summary;
	logic [ADDRESS_BITS-1:0] match_address;
	logic [HIT_BITS-1:0]     hit_count;
	logic                    single_match;

	modport source (output valid, is_summary, match_address, hit_count, single_match,
		input ready);
	modport sink (input valid, is_summary, match_address, hit_count, single_match,
		output ready);
endinterface

interface mbps_cfg_if import mbps_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic [CFG_IDX_BITS-1:0]  index;
	logic [CFG_DATA_BITS-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/masked_byte_pattern_scanner.sv
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner
// streaming wildcard byte pattern search with hit limit and end-of-scan summary
// ----------------------------------------------------------------------------
// The scanner takes one byte per clock and keeps that rate for as long as the
// result side keeps up; a byte is shifted into the window and compared in the
// cycle after its transfer, a hit or summary is then written into the queue and
// from there loaded into the result register, from which it is offered. The
// front end shifts the byte into a window of PATTERN_BYTES entries and
// compares it against up to 16 masked pattern bytes in parallel; only hits
// and end-of-scan items go into a four-entry queue, so a stalled result
// channel does not hold up the byte stream until the queue fills. The back
// end counts hits, drops hits past the limit, remembers the first hit and forms
// the summary. Configuration writes are taken at once and should only be
// issued while the scanner is idle.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner import mbps_pkg::*; #(
	parameter int PATTERN_BYTES = PATTERN_BYTES_DEF,
	parameter int ADDRESS_BITS  = ADDRESS_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	mbps_stream_if.sink   stream,
	mbps_result_if.source result,
	mbps_cfg_if.sink      cfg
);

	localparam int QUEUE_WIDTH = ADDRESS_BITS + 1;

	cfg_regs_t               cfg_q;
	logic                    q_push;
	logic                    q_full;
	logic                    q_pop;
	logic                    q_valid;
	logic                    push_eos;
	logic [ADDRESS_BITS-1:0] push_addr;
	logic [QUEUE_WIDTH-1:0]  q_rd_data;

	// configuration write channel never stalls
	assign cfg.ready = 1'b1;

	// register file; unlisted indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{pattern: '0, compare_mask: '0, pattern_length: '0,
				max_hits: HIT_BITS'(1)};
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_PATTERN_LOW: begin
					cfg_q.pattern[63:0] <= cfg.data;
				end
				REG_PATTERN_HIGH: begin
					cfg_q.pattern[127:64] <= cfg.data;
				end
				REG_COMPARE_MASK: begin
					cfg_q.compare_mask <= cfg.data[REG_BYTES-1:0];
				end
				REG_PATTERN_LENGTH: begin
					cfg_q.pattern_length <= cfg.data[LEN_BITS-1:0];
				end
				REG_MAX_HITS: begin
					cfg_q.max_hits <= cfg.data[HIT_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// front end: window, compare, start address
	mbps_front #(
		.PATTERN_BYTES (PATTERN_BYTES),
		.ADDRESS_BITS  (ADDRESS_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_regs  (cfg_q),
		.stream    (stream),
		.q_full    (q_full),
		.push      (q_push),
		.push_eos  (push_eos),
		.push_addr (push_addr)
	);

	// decoupling queue, entry is {end of scan, start address}
	mbps_queue #(
		.WIDTH (QUEUE_WIDTH),
		.DEPTH (QUEUE_DEPTH_DEF)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({push_eos, push_addr}),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.pop_data  (q_rd_data)
	);

	// back end: counting, limit, summary, result register
	mbps_back #(
		.ADDRESS_BITS (ADDRESS_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_regs (cfg_q),
		.q_valid  (q_valid),
		.q_eos    (q_rd_data[QUEUE_WIDTH-1]),
		.q_addr   (q_rd_data[ADDRESS_BITS-1:0]),
		.pop      (q_pop),
		.result   (result)
	);

endmodule

>>> hdl/mbps_front.sv
// ----------------------------------------------------------------------------
// mbps_front
// byte window, masked compare and start address; pushes hits and summaries
// ----------------------------------------------------------------------------
module mbps_front import mbps_pkg::*; #(
	parameter int PATTERN_BYTES = PATTERN_BYTES_DEF,
	parameter int ADDRESS_BITS  = ADDRESS_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cfg_regs_t               cfg_regs,
	mbps_stream_if.sink             stream,
	input  logic                    q_full,
	output logic                    push,
	output logic                    push_eos,
	output logic [ADDRESS_BITS-1:0] push_addr
);

	localparam int FILL_BITS = $clog2(PATTERN_BYTES + 1);
	localparam int IDX_BITS  = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;
	localparam int CMP_BYTES = (PATTERN_BYTES < REG_BYTES) ? PATTERN_BYTES : REG_BYTES;

	logic [7:0]              window_q [PATTERN_BYTES];
	logic [FILL_BITS-1:0]    fill_q;
	logic [FILL_BITS-1:0]    fill_base;
	logic                    vld_s1;
	logic                    eos_s1;
	logic [ADDRESS_BITS-1:0] addr_s1;
	logic                    accept;
	logic                    match;

	assign stream.ready = ~vld_s1 | ~q_full;
	assign accept       = stream.valid & stream.ready;
	assign fill_base    = stream.span_start ? '0 : fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (accept) begin
				vld_s1 <= 1'b1;
				if (stream.end_of_scan) begin
					fill_q <= '0;
				end else if (fill_base != FILL_BITS'(PATTERN_BYTES)) begin
					fill_q <= fill_base + 1'b1;
				end else begin
					fill_q <= fill_base;
				end
			end else if (!q_full) begin
				vld_s1 <= 1'b0;
			end
		end
	end

	// shift line, newest byte at index 0
	always_ff @(posedge clk) begin
		if (accept) begin
			eos_s1  <= stream.end_of_scan;
			addr_s1 <= stream.byte_address;
			if (!stream.end_of_scan) begin
				window_q[0] <= stream.data_byte;
				for (int k = 1; k < PATTERN_BYTES; k++) begin
					window_q[k] <= window_q[k-1];
				end
			end
		end
	end

	// pattern byte i lines up with window entry length-1-i
	always_comb begin
		logic       any_cmp;
		logic       all_eq;
		logic       len_ok;
		logic [7:0] len_w;
		logic [7:0] widx;
		any_cmp = 1'b0;
		all_eq  = 1'b1;
		len_w   = 8'(cfg_regs.pattern_length);
		len_ok  = (len_w != 8'd0) && (len_w <= 8'(PATTERN_BYTES)) && (8'(fill_q) >= len_w);
		for (int i = 0; i < CMP_BYTES; i++) begin
			widx = len_w - 8'd1 - 8'(i);
			if ((8'(i) < len_w) && cfg_regs.compare_mask[i]) begin
				any_cmp = 1'b1;
				if (window_q[widx[IDX_BITS-1:0]] != cfg_regs.pattern[8*i +: 8]) begin
					all_eq = 1'b0;
				end
			end
		end
		match = len_ok & any_cmp & all_eq;
	end

	assign push      = vld_s1 & ~q_full & (eos_s1 | match);
	assign push_eos  = eos_s1;
	assign push_addr = addr_s1 - ADDRESS_BITS'(cfg_regs.pattern_length) + 1'b1;

endmodule

>>> hdl/mbps_queue.sv
// ----------------------------------------------------------------------------
// mbps_queue
// small register fifo between front and back
// ----------------------------------------------------------------------------
module mbps_queue import mbps_pkg::*; #(
	parameter int WIDTH = ADDRESS_BITS_DEF + 1,
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0]  mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [PTR_BITS:0]   count_q;

	assign full      = (count_q == (PTR_BITS + 1)'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> hdl/mbps_back.sv
// ----------------------------------------------------------------------------
// mbps_back
// hit counting, limit, first hit and summary; result output register
// ----------------------------------------------------------------------------
module mbps_back import mbps_pkg::*; #(
	parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cfg_regs_t               cfg_regs,
	input  logic                    q_valid,
	input  logic                    q_eos,
	input  logic [ADDRESS_BITS-1:0] q_addr,
	output logic                    pop,
	mbps_result_if.source           result
);

	logic [HIT_BITS-1:0]     hits_q;
	logic [HIT_BITS-1:0]     hits_inc;
	logic [ADDRESS_BITS-1:0] first_q;
	logic                    limit_q;
	logic                    out_vld_q;
	logic                    out_free;
	logic                    drop;
	logic                    emit;

	assign out_free = ~out_vld_q | result.ready;
	assign drop     = q_valid & ~q_eos & limit_q;
	assign pop      = q_valid & (drop | out_free);
	assign emit     = pop & ~drop;
	assign hits_inc = hits_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q    <= '0;
			first_q   <= '0;
			limit_q   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
			if (emit) begin
				if (q_eos) begin
					hits_q  <= '0;
					first_q <= '0;
					limit_q <= 1'b0;
				end else begin
					hits_q <= hits_inc;
					if (hits_q == '0) begin
						first_q <= q_addr;
					end
					// a limit of zero is met by the first hit as well
					if (hits_inc >= cfg_regs.max_hits) begin
						limit_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result.is_summary    <= q_eos;
			result.match_address <= q_eos ? first_q : q_addr;
			result.hit_count     <= q_eos ? hits_q : hits_inc;
			result.single_match  <= q_eos & (hits_q == HIT_BITS'(1));
		end
	end

	assign result.valid = out_vld_q;

endmodule

>>> tb/mbps_hit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_hit_checker
// watches the scanner channels, predicts hit reports and summaries from the
// byte and register transfers, and compares every result transfer with them
// ----------------------------------------------------------------------------
module mbps_hit_checker import mbps_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	mbps_stream_if stream,
	mbps_result_if result,
	mbps_cfg_if    cfg,
	output int     fail_count,
	output int     pending
);

	localparam int ADDR_W = ADDRESS_BITS_DEF;
	localparam int WIN    = PATTERN_BYTES_DEF;

	typedef struct packed {
		logic              is_summary;
		logic [ADDR_W-1:0] match_address;
		logic [HIT_BITS-1:0] hit_count;
		logic              single_match;
	} scan_report_t;

	cfg_regs_t           regs;
	logic [7:0]          window [WIN];     // newest byte at index 0
	int                  window_fill;
	logic [HIT_BITS-1:0] hits;
	logic [ADDR_W-1:0]   first_hit;
	bit                  limit_hit;
	scan_report_t        expected_reports [$];
	int                  fails;

	function automatic string show(scan_report_t r);
		return $sformatf("summary=%0b address=%h count=%0d single=%0b",
			r.is_summary, r.match_address, r.hit_count, r.single_match);
	endfunction

	// compared bytes must all agree, wildcards are skipped, at least one compared
	function automatic bit window_hit();
		int len;
		int j;
		bit any;
		len = int'(regs.pattern_length);
		any = 1'b0;
		if (len == 0 || len > WIN || window_fill < len) return 1'b0;
		for (int i = 0; i < len; i++) begin
			if (regs.compare_mask[i[3:0]]) begin
				any = 1'b1;
				j = len - 1 - i;
				if (window[j[3:0]] != 8'(regs.pattern >> (8 * i))) return 1'b0;
			end
		end
		return any;
	endfunction

	task automatic apply_register_write(input logic [CFG_IDX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] value);
		case (idx)
			REG_PATTERN_LOW:    regs.pattern[63:0] = value;
			REG_PATTERN_HIGH:   regs.pattern[127:64] = value;
			REG_COMPARE_MASK:   regs.compare_mask = value[REG_BYTES-1:0];
			REG_PATTERN_LENGTH: regs.pattern_length = value[LEN_BITS-1:0];
			REG_MAX_HITS:       regs.max_hits = value[HIT_BITS-1:0];
			default: ;
		endcase
	endtask

	task automatic advance_scan(input logic [7:0] data, input logic [ADDR_W-1:0] addr,
		input logic span, input logic eos);
		scan_report_t r;
		logic [HIT_BITS-1:0] limit;
		logic [ADDR_W-1:0] start;
		limit = (regs.max_hits == '0) ? HIT_BITS'(1) : regs.max_hits;
		if (eos) begin
			r.is_summary    = 1'b1;
			r.match_address = first_hit;
			r.hit_count     = hits;
			r.single_match  = (hits == HIT_BITS'(1));
			expected_reports.insert(expected_reports.size(), r);
			window_fill = 0;
			hits        = '0;
			first_hit   = '0;
			limit_hit   = 1'b0;
			return;
		end
		if (span) window_fill = 0;
		for (int i = WIN - 1; i > 0; i--) window[i] = window[i - 1];
		window[0] = data;
		if (window_fill < WIN) window_fill++;
		if (limit_hit || !window_hit()) return;
		// start address wraps at the address width
		start = addr - ADDR_W'(regs.pattern_length) + ADDR_W'(1);
		if (hits == '0) first_hit = start;
		hits = hits + 1'b1;
		if (hits >= limit) limit_hit = 1'b1;
		r.is_summary    = 1'b0;
		r.match_address = start;
		r.hit_count     = hits;
		r.single_match  = 1'b0;
		expected_reports.insert(expected_reports.size(), r);
	endtask

	task automatic check_report();
		scan_report_t got;
		scan_report_t want;
		got.is_summary    = result.is_summary;
		got.match_address = result.match_address;
		got.hit_count     = result.hit_count;
		got.single_match  = result.single_match;
		if (expected_reports.size() == 0) begin
			fails++;
			if (fails <= 10) $display("%0t unexpected report: %s", $time, show(got));
		end else begin
			want = expected_reports.pop_front();
			if (got.is_summary !== want.is_summary || got.match_address !== want.match_address
				|| got.hit_count !== want.hit_count || got.single_match !== want.single_match) begin
				fails++;
				if (fails <= 10)
					$display("%0t report mismatch: expected %s, got %s",
						$time, show(want), show(got));
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs          = '0;
			regs.max_hits = HIT_BITS'(1);
			foreach (window[i]) window[i] = '0;
			window_fill = 0;
			hits        = '0;
			first_hit   = '0;
			limit_hit   = 1'b0;
			expected_reports.delete();
			fails = 0;
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (cfg.valid && cfg.ready) apply_register_write(cfg.index, cfg.data);
			if (stream.valid && stream.ready)
				advance_scan(stream.data_byte, stream.byte_address, stream.span_start,
					stream.end_of_scan);
			if (result.valid && result.ready) check_report();
			fail_count <= fails;
			pending    <= expected_reports.size();
		end
	end

endmodule

>>> tb/masked_byte_pattern_scanner_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner_tb
// directed and random byte streams against a self-checking scanner model;
// register settings change between phases while the scanner is idle, both
// sides idle at random and the result side holds off once to fill the queue
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner_tb import mbps_pkg::*;;

	localparam int ADDR_W          = ADDRESS_BITS_DEF;
	localparam int RANDOM_ITEMS    = 500;
	localparam int PHASE_ITEMS     = 40;
	localparam int DRAIN_CYCLES    = 40;    // covers the pipe and dropped hits in the queue
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int WATCHDOG_LIMIT  = 3000;  // well above the hold-off and drain stretches

	logic              clk;
	logic              arst_n;
	int                fail_count;
	int                pending;
	int                items_sent;
	bit                src_idle;
	bit                snk_idle;
	bit                hold_off_req;
	logic [ADDR_W-1:0] next_addr;

	mbps_stream_if stream ();
	mbps_result_if result ();
	mbps_cfg_if    cfg ();

	masked_byte_pattern_scanner DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream),
		.result (result),
		.cfg    (cfg)
	);

	mbps_hit_checker hit_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.stream     (stream),
		.result     (result),
		.cfg        (cfg),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// 4 ns clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// result side: random stalls per transfer, one long hold-off on request
	initial begin : receiver
		int stall;
		result.ready = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_off_req) begin
				// keep ready low while the sender keeps offering bytes
				hold_off_req = 1'b0;
				result.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else begin
				stall = snk_idle ? int'($urandom_range(19, 0)) : 0;
				if (stall > 0) begin
					result.ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			result.ready <= 1'b1;
			do @(posedge clk); while (!result.valid);
		end
	end

	// ends the run when no transfer happens for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (stream.valid && stream.ready) || (result.valid && result.ready)
				|| (cfg.valid && cfg.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL masked_byte_pattern_scanner");
		$finish;
	end

	function automatic logic [ADDR_W-1:0] rand_addr();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[ADDR_W-1:0];
	endfunction

	// valid stays high across back-to-back items, lowered only for a gap
	task automatic send_item(input logic [7:0] data, input logic [ADDR_W-1:0] addr,
		input logic span, input logic eos);
		int gap;
		gap = src_idle ? int'($urandom_range(19, 0)) : 0;
		if (gap > 0) begin
			stream.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		stream.valid        <= 1'b1;
		stream.data_byte    <= data;
		stream.byte_address <= addr;
		stream.span_start   <= span;
		stream.end_of_scan  <= eos;
		do @(posedge clk); while (!stream.ready);
		items_sent++;
	endtask

	task automatic send_byte(input logic [7:0] data, input logic span);
		send_item(data, next_addr, span, 1'b0);
		next_addr = next_addr + ADDR_W'(1);
	endtask

	// byte, address and span flag of an end-of-scan item are don't-cares
	task automatic end_scan();
		send_item(8'($urandom), rand_addr(), 1'($urandom), 1'b1);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		do @(posedge clk); while (!cfg.ready);
	endtask

	task automatic configure(input logic [63:0] lo, input logic [63:0] hi,
		input logic [REG_BYTES-1:0] mask, input int len, input logic [HIT_BITS-1:0] limit);
		write_reg(REG_PATTERN_LOW, lo);
		write_reg(REG_PATTERN_HIGH, hi);
		write_reg(REG_COMPARE_MASK, CFG_DATA_BITS'(mask));
		write_reg(REG_PATTERN_LENGTH, CFG_DATA_BITS'(len));
		write_reg(REG_MAX_HITS, CFG_DATA_BITS'(limit));
		cfg.valid <= 1'b0;
	endtask

	// stop offering, wait for every expected report, then let the pipe drain
	task automatic settle();
		stream.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// one random register setting followed by mostly planted patterns
	task automatic run_phase(input int n_items);
		logic [8*REG_BYTES-1:0] pat;
		logic [REG_BYTES-1:0]   mask;
		logic [HIT_BITS-1:0]    limit;
		int len;
		int plant;
		int brk;
		int sent;
		case ($urandom_range(5, 0))
			0: pat = '0;
			1: pat = '1;
			default: pat = {$urandom, $urandom, $urandom, $urandom};
		endcase
		case ($urandom_range(9, 0))
			0: len = 0;                                   // empty pattern
			1: len = REG_BYTES;
			2: len = int'($urandom_range(31, 17));        // oversized length
			default: len = int'($urandom_range(6, 1));
		endcase
		case ($urandom_range(7, 0))
			0: mask = '0;                                 // all wildcards
			1: mask = '1;
			default: begin
				mask = REG_BYTES'($urandom);
				if (len > 0 && len <= REG_BYTES)
					mask = mask | (REG_BYTES'(1) << $urandom_range(len - 1, 0));
			end
		endcase
		case ($urandom_range(7, 0))
			0: limit = '0;                                // acts as a limit of one
			1: limit = '1;
			2: limit = HIT_BITS'(1);
			default: limit = HIT_BITS'($urandom_range(8, 2));
		endcase
		configure(pat[63:0], pat[127:64], mask, len, limit);

		src_idle = $urandom_range(3, 0) != 0;
		snk_idle = $urandom_range(3, 0) != 0;
		// sometimes start just below the top so start addresses wrap
		if ($urandom_range(4, 0) == 0)
			next_addr = '1 - ADDR_W'($urandom_range(40, 0));
		else
			next_addr = rand_addr();

		plant = (len == 0) ? 4 : ((len > REG_BYTES) ? REG_BYTES : len);
		send_byte(8'($urandom), 1'b1);
		sent = 1;
		while (sent < n_items) begin
			case ($urandom_range(9, 0))
				0, 1, 2, 3, 4: begin
					// planted pattern, now and then cut by a span start
					brk = ($urandom_range(7, 0) == 0) ? int'($urandom_range(plant - 1, 0)) : -1;
					for (int i = 0; i < plant; i++)
						send_byte(mask[i[3:0]] ? 8'(pat >> (8 * i)) : 8'($urandom), i == brk);
					sent += plant;
				end
				5: begin
					send_byte(8'($urandom), 1'b1);
					sent++;
				end
				6: if ($urandom_range(3, 0) == 0) begin
					end_scan();
					sent++;
				end
				default: begin
					// noise, often made of pattern bytes
					if ($urandom_range(1, 0) != 0)
						send_byte(8'(pat >> (8 * $urandom_range(plant - 1, 0))), 1'b0);
					else
						send_byte(8'($urandom), 1'b0);
					sent++;
				end
			endcase
		end
		end_scan();
		settle();
	endtask

	initial begin : stimulus
		int base;
		logic [7:0] p0;
		logic [7:0] p1;
		arst_n              = 1'b0;
		stream.valid        = 1'b0;
		stream.data_byte    = '0;
		stream.byte_address = '0;
		stream.span_start   = 1'b0;
		stream.end_of_scan  = 1'b0;
		cfg.valid           = 1'b0;
		cfg.index           = REG_PATTERN_LOW;
		cfg.data            = '0;
		src_idle            = 1'b0;
		snk_idle            = 1'b0;
		hold_off_req        = 1'b0;
		next_addr           = '0;
		items_sent          = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: pattern de ad ?? ef, byte 2 wildcard, limit of two hits
		configure(64'h0000_0000_EF00_ADDE, '1, 16'h000B, 4, HIT_BITS'(2));
		src_idle  = 1'b1;
		snk_idle  = 1'b1;
		next_addr = 48'hFFFF_FFFF_FFFE;
		// match across the address wrap
		send_byte(8'hDE, 1'b1);
		send_byte(8'hAD, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hEF, 1'b0);
		// span start in the middle breaks the match
		send_byte(8'hDE, 1'b1);
		send_byte(8'hAD, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'hEF, 1'b0);
		// second hit reaches the limit
		send_byte(8'hDE, 1'b0);
		send_byte(8'hAD, 1'b0);
		send_byte(8'h12, 1'b0);
		send_byte(8'hEF, 1'b0);
		// past the limit, no report
		send_byte(8'hDE, 1'b0);
		send_byte(8'hAD, 1'b0);
		send_byte(8'h34, 1'b0);
		send_byte(8'hEF, 1'b0);
		end_scan();
		end_scan();                 // summary of an empty scan
		send_byte(8'hDE, 1'b1);
		send_byte(8'hAD, 1'b0);
		send_byte(8'h56, 1'b0);
		send_byte(8'hEF, 1'b0);
		end_scan();                 // exactly one hit
		settle();

		// back-pressure: a hit every other byte while the result side holds off
		p0 = 8'($urandom);
		p1 = 8'($urandom);
		configure({48'h0, p1, p0}, {$urandom, $urandom}, 16'h0003, 2, '1);
		src_idle     = 1'b0;
		snk_idle     = 1'b0;
		hold_off_req = 1'b1;
		next_addr    = rand_addr();
		for (int i = 0; i < 40; i++) send_byte(i[0] ? p1 : p0, i == 0);
		end_scan();
		settle();

		// random phases, each with its own register setting
		base = items_sent;
		while (items_sent < base + RANDOM_ITEMS) run_phase(PHASE_ITEMS);

		if (fail_count == 0 && pending == 0)
			$display("PASS masked_byte_pattern_scanner");
		else
			$display("FAIL masked_byte_pattern_scanner");
		$finish;
	end

endmodule
